[design/lmfs_pkg.sv]
// lmfs_pkg: shared types, constants and the brightness table of the LED matrix fade scanner
// no dependencies; imported by every module of the block

package lmfs_pkg;

	// fade levels and counter limits
	localparam int unsigned LEVELS    = 64;
	localparam int unsigned CNT_W     = 6;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LEVELS - 1);

	// configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 6;
	localparam logic [CFG_INDEX_W-1:0] REG_FADE_STEP  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INVERT_PWM = 2'd1;

	// table entries with a meaning of their own
	localparam logic [7:0] LEVEL_OFF  = 8'd0;
	localparam logic [7:0] LEVEL_FULL = 8'd255;

	typedef enum logic [1:0] {
		DRIVE_OFF  = 2'd0,
		DRIVE_FULL = 2'd1,
		DRIVE_PWM  = 2'd2
	} drive_mode_t;

	// drive of one row as a lane finds it
	typedef struct packed {
		drive_mode_t mode;
		logic [7:0]  duty;
	} lane_result_t;

	// control shared by all lanes
	typedef struct packed {
		logic                  load;
		logic                  clear;
		logic [CNT_W-1:0]      fade_step;
		logic                  invert;
	} lane_ctrl_t;

	// perceptual brightness curve
	localparam logic [7:0] BRIGHT_TABLE [LEVELS] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd5,   8'd6,
		8'd6,   8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,
		8'd14,  8'd16,  8'd17,  8'd19,  8'd21,  8'd23,  8'd25,  8'd28,
		8'd30,  8'd33,  8'd36,  8'd40,  8'd44,  8'd48,  8'd52,  8'd57,
		8'd62,  8'd68,  8'd74,  8'd81,  8'd89,  8'd97,  8'd106, 8'd115,
		8'd126, 8'd138, 8'd150, 8'd164, 8'd179, 8'd195, 8'd213, 8'd255
	};

	function automatic logic [7:0] bright_level(input logic [CNT_W-1:0] cnt);
		return BRIGHT_TABLE[cnt];
	endfunction

endpackage

[design/lmfs_lane.sv]
// lmfs_lane: one matrix row; holds the fade counters of that row and works out its drive
// depends on lmfs_pkg

module lmfs_lane import lmfs_pkg::*; #(
	parameter int unsigned COLUMNS = 8,
	parameter int unsigned COL_W   = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic [COL_W-1:0]   col,
	input  logic [COLUMNS-1:0] row_bits,
	output lane_result_t       result
);

	logic [CNT_W-1:0] cnt_q [COLUMNS];
	logic [CNT_W-1:0] cnt_rd;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W:0]   cnt_sum;
	logic [7:0]       level;
	logic             led_on;
	logic             hold_full;
	lane_result_t     res_comb;
	lane_result_t     res_s1;

	// counter and state of the led in the active column
	assign cnt_rd    = cnt_q[col];
	assign led_on    = row_bits[col];
	assign level     = bright_level(cnt_rd);
	assign hold_full = (ctrl.fade_step == '0) && led_on;
	assign cnt_sum   = {1'b0, cnt_rd} + {1'b0, ctrl.fade_step};

	// drive from the table entry; an on led with fading disabled is driven full on
	always_comb begin
		res_comb.mode = DRIVE_OFF;
		res_comb.duty = '0;
		if (hold_full) begin
			res_comb.mode = DRIVE_FULL;
		end else if (level == LEVEL_FULL) begin
			res_comb.mode = DRIVE_FULL;
		end else if (level != LEVEL_OFF) begin
			res_comb.mode = DRIVE_PWM;
			res_comb.duty = ctrl.invert ? ~level : level;
		end
	end

	// step the counter toward its target and clamp
	always_comb begin
		cnt_next = cnt_rd;
		if (led_on) begin
			cnt_next = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[CNT_W-1:0];
		end else if (cnt_rd > ctrl.fade_step) begin
			cnt_next = cnt_rd - ctrl.fade_step;
		end else begin
			cnt_next = '0;
		end
	end

	// counter store, one entry per column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < COLUMNS; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int c = 0; c < COLUMNS; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (ctrl.load && !hold_full) begin
			cnt_q[col] <= cnt_next;
		end
	end

	// registered drive of this row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '{mode: DRIVE_OFF, duty: '0};
		end else if (ctrl.load) begin
			res_s1 <= res_comb;
		end
	end

	assign result = res_s1;

	// an on led with fading disabled is driven full on
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.load && ctrl.fade_step == '0 && led_on) |=> res_s1.mode == DRIVE_FULL)
		else $error("lane: led on with fading disabled not driven full on");

	// duty only carries a value in pwm mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1.mode != DRIVE_PWM) |-> res_s1.duty == '0)
		else $error("lane: duty set outside pwm mode");

	// clearing empties the counters; checked on the counter of column zero
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> cnt_q[0] == '0)
		else $error("lane: counter not cleared");

endmodule

[design/lmfs_merge.sv]
// lmfs_merge: collects the lane results of one tick and hands them out one row a cycle
// while out_ready is high; depends on lmfs_pkg

module lmfs_merge import lmfs_pkg::*; #(
	parameter int unsigned ROWS  = 8,
	parameter int unsigned ROW_W = 3,
	parameter int unsigned COL_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [COL_W-1:0] col,
	input  lane_result_t     results [ROWS],
	input  logic             out_ready,
	output logic             free,
	output logic             out_valid,
	output logic [COL_W-1:0] col_out,
	output logic [ROW_W-1:0] row_out,
	output lane_result_t     res_out,
	output logic             row_last
);

	logic             busy_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             out_take;

	assign row_last  = (row_q == ROW_W'(ROWS - 1));
	assign out_take  = busy_q && out_ready;
	assign free      = !busy_q || (out_ready && row_last);
	assign out_valid = busy_q;
	assign col_out   = col_q;
	assign row_out   = row_q;
	assign res_out   = results[row_q];

	// row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			row_q  <= '0;
		end else if (out_take) begin
			if (row_last) begin
				busy_q <= 1'b0;
				row_q  <= '0;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// column of the tick in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (load) begin
			col_q <= col;
		end
	end

	// a new tick starts at its first row
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (busy_q && row_q == '0))
		else $error("merge: new tick does not start at row zero");

	// rows advance by one per taken row
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !row_last && !load) |=> row_q == ROW_W'($past(row_q) + 1'b1))
		else $error("merge: row skipped or repeated");

	// row never leaves the matrix
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> row_q <= ROW_W'(ROWS - 1))
		else $error("merge: row beyond matrix");

endmodule

[design/led_matrix_fade_scanner.sv]
// led_matrix_fade_scanner: the first row result is valid in the cycle after a request
// is taken, then one row result per cycle while out_ready is high, ROWS results per
// request. the next request is taken in the cycle that the last row leaves, set by the
// row sequencer.
// reset clears all fade counters, the active column and both registers at once;
// a fade_step write clears every fade counter together. no clearing pass.

module led_matrix_fade_scanner import lmfs_pkg::*; #(
	parameter int unsigned COLUMNS = 8,
	parameter int unsigned ROWS    = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [63:0]            led_states,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             column,
	output logic [2:0]             row,
	output logic [1:0]             drive_mode,
	output logic [7:0]             duty,
	output logic                   last
);

	localparam int unsigned COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [CNT_W-1:0] fade_step_q;
	logic             invert_q;
	logic [COL_W-1:0] active_col_q;
	logic             load;
	logic             free;
	lane_ctrl_t       ctrl;
	lane_result_t     results [ROWS];
	lane_result_t     res_out;
	logic [COL_W-1:0] col_out;
	logic [ROW_W-1:0] row_out;

	assign in_ready = free;
	assign load     = in_valid && free;

	assign ctrl.load      = load;
	assign ctrl.clear     = cfg_write && (cfg_index == REG_FADE_STEP);
	assign ctrl.fade_step = fade_step_q;
	assign ctrl.invert    = invert_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q <= '0;
			invert_q    <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == REG_FADE_STEP) begin
				fade_step_q <= cfg_data[CNT_W-1:0];
			end else if (cfg_index == REG_INVERT_PWM) begin
				invert_q <= cfg_data[0];
			end
		end
	end

	// active column, wraps after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_col_q <= '0;
		end else if (load) begin
			if (active_col_q == COL_W'(COLUMNS - 1)) begin
				active_col_q <= '0;
			end else begin
				active_col_q <= active_col_q + 1'b1;
			end
		end
	end

	// one lane per row
	for (genvar r = 0; r < ROWS; r++) begin : g_lane
		lmfs_lane #(
			.COLUMNS (COLUMNS),
			.COL_W   (COL_W)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.col      (active_col_q),
			.row_bits (led_states[r*COLUMNS +: COLUMNS]),
			.result   (results[r])
		);
	end

	// row by row hand-out
	lmfs_merge #(
		.ROWS  (ROWS),
		.ROW_W (ROW_W),
		.COL_W (COL_W)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.col       (active_col_q),
		.results   (results),
		.out_ready (out_ready),
		.free      (free),
		.out_valid (out_valid),
		.col_out   (col_out),
		.row_out   (row_out),
		.res_out   (res_out),
		.row_last  (last)
	);

	assign column     = 3'(col_out);
	assign row        = 3'(row_out);
	assign drive_mode = res_out.mode;
	assign duty       = res_out.duty;

endmodule
